@@ sv/ddu_pkg.sv @@
package ddu_pkg;

	localparam int RES_TYPES  = 3;
	localparam int RES_W      = 16;
	localparam int PROC_W     = 4;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// register index, taken from paddr[3:2]
	localparam logic [1:0] REG_AVAIL0 = 2'd0;
	localparam logic [1:0] REG_AVAIL1 = 2'd1;
	localparam logic [1:0] REG_AVAIL2 = 2'd2;

	typedef logic [RES_TYPES-1:0][RES_W-1:0] res_vec_t;

	typedef struct packed {
		logic [RES_W-1:0] alloc_r0;
		logic [RES_W-1:0] alloc_r1;
		logic [RES_W-1:0] alloc_r2;
		logic [RES_W-1:0] req_r0;
		logic [RES_W-1:0] req_r1;
		logic [RES_W-1:0] req_r2;
		logic             last_row;
	} row_item_t;

	typedef struct packed {
		logic              is_safe;
		logic [PROC_W-1:0] proc_index;
		logic              last_result;
	} result_item_t;

	typedef struct packed {
		logic row_wr;
		logic run_init;
		logic scan_rd;
		logic safe_rd;
		logic unsafe_chk;
		logic out_last;
	} ddu_cmd_t;

	typedef struct packed {
		logic fit;
		logic unfin;
	} ddu_sts_t;

endpackage

@@ sv/ddu_dp.sv @@
module ddu_dp import ddu_pkg::*; #(
	parameter int MAX_PROCS = 16
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  ddu_cmd_t                                              cmd,
	input  logic [((MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1)-1:0] wr_addr,
	input  logic [((MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1)-1:0] rd_addr,
	input  logic [((MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1)-1:0] seq_addr,
	input  row_item_t                                             row,
	input  res_vec_t                                              avail,
	output ddu_sts_t                                              sts,
	output result_item_t                                          result,
	output logic                                                  result_stb
);

	localparam int PIDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CNT_W  = $clog2(MAX_PROCS + 1);
	localparam int WORK_W = RES_W + CNT_W;
	localparam int ROW_W  = 2 * RES_TYPES * RES_W;

	typedef logic [RES_TYPES-1:0][WORK_W-1:0] work_vec_t;

	logic [ROW_W-1:0]  row_mem [MAX_PROCS];
	logic [PROC_W-1:0] seq_mem [MAX_PROCS];

	logic [ROW_W-1:0]     row_s1;
	logic [PIDX_W-1:0]    pidx_s1;
	logic                 eval_s1;
	work_vec_t            work_q;
	logic [MAX_PROCS-1:0] mask_q;
	result_item_t         result_q;
	logic                 result_stb_q;

	res_vec_t   alloc_s1;
	res_vec_t   req_s1;
	logic       fits;
	logic       fit;
	logic       unfin;

	// row layout: allocation in the upper half, request in the lower half
	assign alloc_s1 = res_vec_t'(row_s1[ROW_W-1 -: RES_TYPES*RES_W]);
	assign req_s1   = res_vec_t'(row_s1[RES_TYPES*RES_W-1:0]);

	always_comb begin
		fits = 1'b1;
		for (int k = 0; k < RES_TYPES; k++) begin
			if (WORK_W'(req_s1[k]) > work_q[k]) begin
				fits = 1'b0;
			end
		end
	end

	assign fit   = eval_s1 && !mask_q[pidx_s1] && fits;
	assign unfin = !mask_q[rd_addr];

	assign sts.fit   = fit;
	assign sts.unfin = unfin;

	always_ff @(posedge clk) begin
		if (cmd.row_wr) begin
			row_mem[wr_addr] <= {row.alloc_r2, row.alloc_r1, row.alloc_r0,
				row.req_r2, row.req_r1, row.req_r0};
		end
		row_s1  <= row_mem[rd_addr];
		pidx_s1 <= rd_addr;
		if (fit) begin
			seq_mem[seq_addr] <= PROC_W'(pidx_s1);
		end
		if (cmd.safe_rd) begin
			result_q.is_safe     <= 1'b1;
			result_q.proc_index  <= seq_mem[rd_addr];
			result_q.last_result <= cmd.out_last;
		end else if (cmd.unsafe_chk) begin
			result_q.is_safe     <= 1'b0;
			result_q.proc_index  <= PROC_W'(rd_addr);
			result_q.last_result <= cmd.out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eval_s1      <= 1'b0;
			work_q       <= '0;
			mask_q       <= '0;
			result_stb_q <= 1'b0;
		end else begin
			eval_s1      <= cmd.scan_rd;
			result_stb_q <= cmd.safe_rd || (cmd.unsafe_chk && unfin);
			if (cmd.run_init) begin
				mask_q <= '0;
				for (int k = 0; k < RES_TYPES; k++) begin
					work_q[k] <= WORK_W'(avail[k]);
				end
			end else if (fit) begin
				mask_q[pidx_s1] <= 1'b1;
				for (int k = 0; k < RES_TYPES; k++) begin
					work_q[k] <= work_q[k] + WORK_W'(alloc_s1[k]);
				end
			end
		end
	end

	assign result     = result_q;
	assign result_stb = result_stb_q;

endmodule

@@ sv/ddu_ctrl.sv @@
module ddu_ctrl import ddu_pkg::*; #(
	parameter int MAX_PROCS = 16
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  start,
	input  logic                                                  last_row,
	input  ddu_sts_t                                              sts,
	output logic                                                  busy,
	output ddu_cmd_t                                              cmd,
	output logic [((MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1)-1:0] wr_addr,
	output logic [((MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1)-1:0] rd_addr,
	output logic [((MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1)-1:0] seq_addr
);

	localparam int PIDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
	localparam int CNT_W  = $clog2(MAX_PROCS + 1);

	localparam logic [2:0] ST_LOAD       = 3'd0;
	localparam logic [2:0] ST_SCAN       = 3'd1;
	localparam logic [2:0] ST_DRAIN      = 3'd2;
	localparam logic [2:0] ST_DECIDE     = 3'd3;
	localparam logic [2:0] ST_OUT_SAFE   = 3'd4;
	localparam logic [2:0] ST_OUT_UNSAFE = 3'd5;

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  row_count_q;
	logic [CNT_W-1:0]  n_q;
	logic [PIDX_W-1:0] idx_q;
	logic [CNT_W-1:0]  done_q;
	logic [CNT_W-1:0]  emit_q;
	logic              progress_q;

	logic accept;
	logic full;
	logic idx_last;
	logic emit_last;

	assign busy      = (state_q != ST_LOAD);
	assign accept    = start && !busy;
	assign full      = (row_count_q == CNT_W'(MAX_PROCS));
	assign idx_last  = (CNT_W'(idx_q) == n_q - CNT_W'(1));
	assign emit_last = ((emit_q + CNT_W'(1)) == (n_q - done_q));

	assign wr_addr  = row_count_q[PIDX_W-1:0];
	assign rd_addr  = idx_q;
	assign seq_addr = done_q[PIDX_W-1:0];

	always_comb begin
		cmd            = '0;
		cmd.row_wr     = accept && !full;
		cmd.run_init   = accept && last_row;
		cmd.scan_rd    = (state_q == ST_SCAN);
		cmd.safe_rd    = (state_q == ST_OUT_SAFE);
		cmd.unsafe_chk = (state_q == ST_OUT_UNSAFE);
		cmd.out_last   = (state_q == ST_OUT_SAFE) ? idx_last : emit_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			row_count_q <= '0;
			n_q         <= '0;
			idx_q       <= '0;
			done_q      <= '0;
			emit_q      <= '0;
			progress_q  <= 1'b0;
		end else begin
			if (sts.fit) begin
				done_q     <= done_q + CNT_W'(1);
				progress_q <= 1'b1;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (last_row) begin
							n_q         <= full ? row_count_q : row_count_q + CNT_W'(1);
							row_count_q <= '0;
							done_q      <= '0;
							progress_q  <= 1'b0;
							idx_q       <= '0;
							state_q     <= ST_SCAN;
						end else if (!full) begin
							row_count_q <= row_count_q + CNT_W'(1);
						end
					end
				end
				ST_SCAN: begin
					if (idx_last) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + PIDX_W'(1);
					end
				end
				// last row of the pass is evaluated here
				ST_DRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					idx_q  <= '0;
					emit_q <= '0;
					if (done_q == n_q) begin
						state_q <= ST_OUT_SAFE;
					end else if (!progress_q) begin
						state_q <= ST_OUT_UNSAFE;
					end else begin
						progress_q <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_OUT_SAFE: begin
					if (idx_last) begin
						state_q <= ST_LOAD;
					end else begin
						idx_q <= idx_q + PIDX_W'(1);
					end
				end
				ST_OUT_UNSAFE: begin
					if (sts.unfin) begin
						emit_q <= emit_q + CNT_W'(1);
					end
					if (idx_last) begin
						state_q <= ST_LOAD;
					end else begin
						idx_q <= idx_q + PIDX_W'(1);
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	a_done_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_LOAD) |-> (done_q <= n_q))
		else $error("finished count exceeds row count");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		row_count_q <= CNT_W'(MAX_PROCS))
		else $error("row count beyond store depth");

	a_safe_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && done_q == n_q) |=> (state_q == ST_OUT_SAFE))
		else $error("all rows finished but no safe listing");

	a_fit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		sts.fit |-> ($past(state_q) == ST_SCAN))
		else $error("row finished outside a pass");

endmodule

@@ sv/deadlock_detection_unit.sv @@
// channel   ports                          transfer
// config    psel penable pwrite paddr      write at psel & penable & pwrite & pready
//           pwdata prdata pready
// rows      start busy row                 start & !busy
// results   result_stb result              a one-cycle strobe per result, no back-pressure
//
// each row is taken when start is high and busy is low; the last row starts detection and raises busy
// a pass reads the n rows in order, one row memory read per cycle, then drains and decides
// up to n passes, then a listing that steps through all n entries
// reset clears counters, finished mask, work vector and avail registers
// the results cannot be stalled; the next load starts once busy drops
module deadlock_detection_unit import ddu_pkg::*; #(
	parameter int MAX_PROCS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	input  logic                  start,
	output logic                  busy,
	input  row_item_t             row,
	output result_item_t          result,
	output logic                  result_stb
);

	localparam int PIDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

	res_vec_t          avail_q;
	ddu_cmd_t          cmd;
	ddu_sts_t          sts;
	logic [PIDX_W-1:0] wr_addr;
	logic [PIDX_W-1:0] rd_addr;
	logic [PIDX_W-1:0] seq_addr;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avail_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_AVAIL0: avail_q[0] <= pwdata[RES_W-1:0];
				REG_AVAIL1: avail_q[1] <= pwdata[RES_W-1:0];
				REG_AVAIL2: avail_q[2] <= pwdata[RES_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_AVAIL0: prdata = APB_DATA_W'(avail_q[0]);
			REG_AVAIL1: prdata = APB_DATA_W'(avail_q[1]);
			REG_AVAIL2: prdata = APB_DATA_W'(avail_q[2]);
			default:    prdata = '0;
		endcase
	end

	ddu_ctrl #(
		.MAX_PROCS(MAX_PROCS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.last_row(row.last_row),
		.sts     (sts),
		.busy    (busy),
		.cmd     (cmd),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr),
		.seq_addr(seq_addr)
	);

	ddu_dp #(
		.MAX_PROCS(MAX_PROCS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.seq_addr  (seq_addr),
		.row       (row),
		.avail     (avail_q),
		.sts       (sts),
		.result    (result),
		.result_stb(result_stb)
	);

endmodule

@@ tb/tb_deadlock_detection_unit.sv @@
`timescale 1ns / 1ps

module tb_deadlock_detection_unit;
	import ddu_pkg::*;

	localparam int MAX_ROWS      = 16;
	localparam int RANDOM_ROWS   = 360;
	localparam int SETTLE_CYCLES = 10;
	localparam int TAIL_CYCLES   = 400;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic                  clk     = 1'b0;
	logic                  arst_n  = 1'b0;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [APB_ADDR_W-1:0] paddr   = '0;
	logic [APB_DATA_W-1:0] pwdata  = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  start   = 1'b0;
	logic                  busy;
	row_item_t             row     = '0;
	result_item_t          result;
	logic                  result_stb;

	deadlock_detection_unit #(
		.MAX_PROCS(MAX_ROWS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.start     (start),
		.busy      (busy),
		.row       (row),
		.result    (result),
		.result_stb(result_stb)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow of the block: avail registers, held rows
	logic [RES_W-1:0] avail_shadow [RES_TYPES];
	logic [RES_W-1:0] held_alloc [MAX_ROWS][RES_TYPES];
	logic [RES_W-1:0] held_req [MAX_ROWS][RES_TYPES];
	int unsigned      rows_held = 0;

	row_item_t        rows_to_send [$];
	result_item_t     pending_verdicts [$];
	int unsigned      rows_queued = 0;
	int unsigned      rows_accepted = 0;
	int unsigned      gap_left = 0;
	bit               steady_sender = 1'b0;
	int unsigned      mismatch_count = 0;
	int unsigned      results_checked = 0;
	int unsigned      safe_runs = 0;
	int unsigned      unsafe_runs = 0;
	result_item_t     want;

	initial begin
		for (int k = 0; k < RES_TYPES; k++)
			avail_shadow[k] = '0;
	end

	function automatic void predict_detection(input row_item_t r);
		logic [63:0]       work [RES_TYPES];
		bit                finished [MAX_ROWS];
		logic [PROC_W-1:0] order [MAX_ROWS];
		int unsigned       n, done, p, k;
		bit                progress, fits;
		result_item_t      res;
		if (rows_held < MAX_ROWS) begin
			held_alloc[rows_held][0] = r.alloc_r0;
			held_alloc[rows_held][1] = r.alloc_r1;
			held_alloc[rows_held][2] = r.alloc_r2;
			held_req[rows_held][0] = r.req_r0;
			held_req[rows_held][1] = r.req_r1;
			held_req[rows_held][2] = r.req_r2;
			rows_held++;
		end
		if (!r.last_row)
			return;
		n = rows_held;
		rows_held = 0;
		for (k = 0; k < RES_TYPES; k++)
			work[k] = 64'(avail_shadow[k]);
		for (p = 0; p < MAX_ROWS; p++)
			finished[p] = 1'b0;
		done = 0;
		progress = 1'b1;
		while (done < n && progress) begin
			progress = 1'b0;
			for (p = 0; p < n; p++) begin
				if (!finished[p]) begin
					fits = 1'b1;
					for (k = 0; k < RES_TYPES; k++)
						if (64'(held_req[p][k]) > work[k])
							fits = 1'b0;
					// allocation goes back to work at once, later rows of this pass see it
					if (fits) begin
						for (k = 0; k < RES_TYPES; k++)
							work[k] += 64'(held_alloc[p][k]);
						order[done] = PROC_W'(p);
						done++;
						finished[p] = 1'b1;
						progress = 1'b1;
					end
				end
			end
		end
		if (done == n) begin
			safe_runs++;
			for (p = 0; p < n; p++) begin
				res.is_safe = 1'b1;
				res.proc_index = order[p];
				res.last_result = (p + 1 == n);
				pending_verdicts.push_back(res);
			end
		end else begin
			unsafe_runs++;
			for (p = 0; p < n; p++) begin
				if (!finished[p]) begin
					res.is_safe = 1'b0;
					res.proc_index = PROC_W'(p);
					res.last_result = 1'b0;
					pending_verdicts.push_back(res);
				end
			end
			pending_verdicts[pending_verdicts.size() - 1].last_result = 1'b1;
		end
	endfunction

	// row driver: start stays high across back-to-back transfers
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			row <= '0;
			gap_left = 0;
		end else if (start && !busy) begin
			predict_detection(row);
			rows_accepted++;
			gap_left = steady_sender ? 0 : $urandom_range(0, 8);
			if (gap_left == 0 && rows_to_send.size() != 0)
				row <= rows_to_send.pop_front();
			else
				start <= 1'b0;
		end else if (!start) begin
			if (gap_left != 0) begin
				gap_left--;
			end else if (rows_to_send.size() != 0) begin
				start <= 1'b1;
				row <= rows_to_send.pop_front();
			end
		end
	end

	// result monitor: no back-pressure, every strobe is a transfer
	always @(posedge clk) begin
		if (arst_n && result_stb) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected result: is_safe=%0b proc_index=%0d last_result=%0b",
					$time, result.is_safe, result.proc_index, result.last_result);
				mismatch_count++;
			end else begin
				want = pending_verdicts.pop_front();
				results_checked++;
				if (result.is_safe !== want.is_safe || result.proc_index !== want.proc_index
						|| result.last_result !== want.last_result) begin
					$display("%0t: expected is_safe=%0b proc_index=%0d last_result=%0b, got is_safe=%0b proc_index=%0d last_result=%0b",
						$time, want.is_safe, want.proc_index, want.last_result,
						result.is_safe, result.proc_index, result.last_result);
					mismatch_count++;
				end
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [APB_DATA_W-1:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx < RES_TYPES)
			avail_shadow[idx] = val[RES_W-1:0];
	endtask

	task automatic queue_row(input logic [RES_W-1:0] a0, a1, a2, q0, q1, q2,
			input logic last_row);
		row_item_t r;
		r.alloc_r0 = a0;
		r.alloc_r1 = a1;
		r.alloc_r2 = a2;
		r.req_r0 = q0;
		r.req_r1 = q1;
		r.req_r2 = q2;
		r.last_row = last_row;
		rows_to_send.push_back(r);
		rows_queued++;
	endtask

	// idle: every row sent, every result in, busy low, then a short settle
	task automatic drain();
		while (rows_accepted != rows_queued || pending_verdicts.size() != 0 || busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [RES_W-1:0] rand_units(input int unsigned limit);
		if ($urandom_range(0, 15) == 0)
			return RES_W'($urandom);
		return RES_W'($urandom_range(0, limit));
	endfunction

	function automatic logic [APB_DATA_W-1:0] random_avail();
		logic [RES_W-1:0] units;
		case ($urandom_range(0, 5))
			0: units = '0;
			1: units = '1;
			5: units = RES_W'($urandom);
			default: units = RES_W'($urandom_range(0, 40));
		endcase
		// junk in the upper half must be dropped
		return {16'($urandom), units};
	endfunction

	task automatic queue_random_load();
		int unsigned len, sel, alim, rlim, i;
		bit split;
		sel = $urandom_range(0, 9);
		if (sel < 7)
			len = $urandom_range(1, 6);
		else if (sel < 9)
			len = $urandom_range(7, 16);
		else
			len = $urandom_range(17, 20);
		alim = $urandom_range(0, 12);
		rlim = $urandom_range(0, 40);
		split = ($urandom_range(0, 7) == 0) && (len > 1);
		for (i = 0; i < len; i++) begin
			// avail change in the middle of a load
			if (split && i == len / 2) begin
				drain();
				write_reg(2'($urandom_range(0, RES_TYPES - 1)), random_avail());
			end
			queue_row(rand_units(alim), rand_units(alim), rand_units(alim),
				rand_units(rlim), rand_units(rlim), rand_units(rlim), i == len - 1);
		end
	endtask

	initial begin
		int unsigned k, directed_rows;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// avail at reset is zero, an empty request still finishes
		queue_row(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
		drain();

		// all ones everywhere
		for (k = 0; k < RES_TYPES; k++)
			write_reg(2'(k), 32'hA5A5_FFFF);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		queue_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		drain();

		// second pass needed: row 1 frees what row 0 asks for
		for (k = 0; k < RES_TYPES; k++)
			write_reg(2'(k), 32'h0000_0000);
		queue_row(16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 16'd0, 1'b0);
		queue_row(16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
		drain();

		// deadlock: rows 0 and 1 stay unfinished
		queue_row(16'd0, 16'd0, 16'd0, 16'd5, 16'd0, 16'd0, 1'b0);
		queue_row(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd7, 1'b0);
		queue_row(16'd2, 16'd2, 16'd2, 16'd0, 16'd0, 16'd0, 1'b1);
		drain();

		// avail written while a load is half done
		queue_row(16'd4, 16'd4, 16'd4, 16'd3, 16'd0, 16'd0, 1'b0);
		drain();
		write_reg(REG_AVAIL0, 32'h0000_0003);
		queue_row(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
		drain();

		// store full: the row past the limit is dropped but still starts the run
		for (k = 0; k < MAX_ROWS; k++)
			queue_row(16'(k), 16'd0, 16'(k * 3), 16'd0, 16'd0, 16'd0, 1'b0);
		queue_row(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		drain();

		directed_rows = rows_queued;
		while (rows_queued < directed_rows + RANDOM_ROWS) begin
			steady_sender = ($urandom_range(0, 3) == 0);
			for (k = 0; k < RES_TYPES; k++)
				if ($urandom_range(0, 3) != 0)
					write_reg(2'(k), random_avail());
			if ($urandom_range(0, 9) == 0)
				write_reg(REG_UNUSED, $urandom);
			repeat ($urandom_range(1, 4)) queue_random_load();
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_verdicts.size() != 0)
			$display("%0t: %0d expected results never arrived", $time, pending_verdicts.size());
		$display("loaded %0d rows over %0d detection runs (%0d safe, %0d deadlocked)",
			rows_accepted, safe_runs + unsafe_runs, safe_runs, unsafe_runs);
		$display("checked %0d result transfers, %0d mismatches", results_checked, mismatch_count);
		if (mismatch_count == 0 && pending_verdicts.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#1_000_000;
		$display("%0t: timeout", $time);
		$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ deadlock_detection_unit.f @@
sv/ddu_pkg.sv
sv/ddu_dp.sv
sv/ddu_ctrl.sv
sv/deadlock_detection_unit.sv
tb/tb_deadlock_detection_unit.sv
